// File: design/mhfc_pkg.sv
package mhfc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1048576;

  localparam int unsigned HDR_BYTES = 24;
  localparam int unsigned CMD_END   = 4;
  localparam int unsigned LEN_BASE  = 12;
  localparam int unsigned CHK_BASE  = 16;
  localparam int unsigned MAG_BASE  = 20;
  localparam logic [31:0] MAGIC_INV = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_HDR = 3'd1,
    ST_MAGIC_BAD = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_CSUM_BAD  = 3'd4,
    ST_EXTRA     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload_length;
    logic [31:0] command_word;
  } result_t;

endpackage

// File: design/mhfc_if.sv
interface mhfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mhfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] payload_length;
  logic [31:0] command_word;

  modport source (output valid, output status, output payload_length,
                  output command_word, input ready);
  modport sink (input valid, input status, input payload_length,
                input command_word, output ready);
endinterface

// File: design/mhfc_in_stage.sv
module mhfc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mhfc_pkg::beat_t in_beat,
  input  logic            advance,
  output logic            in_ready,
  output logic            beat_valid,
  output mhfc_pkg::beat_t beat
);

  logic            valid_r;
  logic            valid_nxt;
  mhfc_pkg::beat_t beat_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

// File: design/mhfc_accum.sv
module mhfc_accum #(
  parameter int unsigned MAX_PAYLOAD = mhfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_valid,
  input  mhfc_pkg::beat_t   beat,
  input  logic              advance,
  output logic              res_valid,
  output mhfc_pkg::result_t result
);

  localparam int unsigned POS_LIMIT = mhfc_pkg::HDR_BYTES + MAX_PAYLOAD + 1;
  localparam int unsigned POS_W     = $clog2(POS_LIMIT + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      cmd_r, cmd_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      chk_r, chk_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic             fire;
  logic [32:0]      idx_ext;
  logic [32:0]      offset;
  logic [32:0]      size;
  logic [32:0]      need;

  assign fire    = beat_valid && advance;
  assign idx_ext = 33'(pos_r);
  assign offset  = idx_ext - 33'(mhfc_pkg::HDR_BYTES);

  always_comb begin
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    chk_nxt = chk_r;
    mag_nxt = mag_r;
    sum_nxt = sum_r;
    if (idx_ext < 33'(mhfc_pkg::HDR_BYTES)) begin
      if (idx_ext < 33'(mhfc_pkg::CMD_END)) begin
        cmd_nxt[8*pos_r[1:0] +: 8] = beat.data_byte;
      end else if (idx_ext >= 33'(mhfc_pkg::LEN_BASE) &&
                   idx_ext < 33'(mhfc_pkg::CHK_BASE)) begin
        len_nxt[8*pos_r[1:0] +: 8] = beat.data_byte;
      end else if (idx_ext >= 33'(mhfc_pkg::CHK_BASE) &&
                   idx_ext < 33'(mhfc_pkg::MAG_BASE)) begin
        chk_nxt[8*pos_r[1:0] +: 8] = beat.data_byte;
      end else if (idx_ext >= 33'(mhfc_pkg::MAG_BASE)) begin
        mag_nxt[8*pos_r[1:0] +: 8] = beat.data_byte;
      end
    end else if (idx_ext < 33'(POS_LIMIT) && offset < {1'b0, len_r}) begin
      sum_nxt = sum_r + 32'(beat.data_byte);
    end
    pos_nxt = (idx_ext < 33'(POS_LIMIT)) ? pos_r + POS_W'(1) : POS_W'(POS_LIMIT);
  end

  assign size = 33'(pos_nxt);
  assign need = 33'(mhfc_pkg::HDR_BYTES) + {1'b0, len_nxt};

  always_comb begin
    priority if (size < 33'(mhfc_pkg::HDR_BYTES)) begin
      result.status = mhfc_pkg::ST_SHORT_HDR;
    end else if (cmd_nxt != (mag_nxt ^ mhfc_pkg::MAGIC_INV)) begin
      result.status = mhfc_pkg::ST_MAGIC_BAD;
    end else if (size < need) begin
      result.status = mhfc_pkg::ST_TRUNC;
    end else if (chk_nxt != sum_nxt) begin
      result.status = mhfc_pkg::ST_CSUM_BAD;
    end else if (size != need) begin
      result.status = mhfc_pkg::ST_EXTRA;
    end else begin
      result.status = mhfc_pkg::ST_OK;
    end
    result.payload_length = (result.status == mhfc_pkg::ST_OK) ? len_nxt : 32'd0;
    result.command_word   = cmd_nxt;
  end

  assign res_valid = fire && beat.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
      chk_r <= '0;
      mag_r <= '0;
      sum_r <= '0;
    end else if (fire) begin
      if (beat.last_byte) begin
        pos_r <= '0;
        cmd_r <= '0;
        len_r <= '0;
        chk_r <= '0;
        mag_r <= '0;
        sum_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        cmd_r <= cmd_nxt;
        len_r <= len_nxt;
        chk_r <= chk_nxt;
        mag_r <= mag_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

endmodule

// File: design/mhfc_out_stage.sv
module mhfc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  mhfc_pkg::result_t result,
  input  logic              out_ready,
  output logic              advance,
  output logic              out_valid,
  output mhfc_pkg::result_t out_result
);

  logic              valid_r;
  mhfc_pkg::result_t res_r;

  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

// File: design/message_header_frame_checker_top.sv
// Checks one message a byte at a time: the first 24 bytes are a little-endian header
// (command, length, checksum, magic), the rest is payload summed into a 32-bit
// wrapping checksum. One verdict beat leaves for each input beat flagged as the last
// byte, via the input and result registers; other bytes give no output. Unless a
// downstream stall holds the whole two-stage pipeline, a byte is accepted every
// cycle, since the counter step, header capture and one 32-bit add sit between the
// input register and the result register. Messages longer than the header plus
// MAX_PAYLOAD plus one byte are judged as if they had exactly that many bytes.
module message_header_frame_checker_top #(
  parameter int unsigned MAX_PAYLOAD = mhfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mhfc_in_if.sink          in_ch,
  mhfc_out_if.source       out_ch
);

  mhfc_pkg::beat_t   in_beat;
  mhfc_pkg::beat_t   beat;
  mhfc_pkg::result_t result;
  mhfc_pkg::result_t out_result;
  logic              beat_valid;
  logic              res_valid;
  logic              advance;
  logic              out_valid;
  logic              in_ready;

  assign in_beat.data_byte = in_ch.data_byte;
  assign in_beat.last_byte = in_ch.last_byte;
  assign in_ch.ready       = in_ready;

  mhfc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_beat    (in_beat),
    .advance    (advance),
    .in_ready   (in_ready),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  mhfc_accum #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .advance    (advance),
    .res_valid  (res_valid),
    .result     (result)
  );

  mhfc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .result     (result),
    .out_ready  (out_ch.ready),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_result.status;
  assign out_ch.payload_length = out_result.payload_length;
  assign out_ch.command_word   = out_result.command_word;

  a_len_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status != mhfc_pkg::ST_OK) |->
      out_result.payload_length == 32'd0)
    else $error("payload length set on a failing verdict");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.status == mhfc_pkg::ST_OK ||
                   out_result.status == mhfc_pkg::ST_SHORT_HDR ||
                   out_result.status == mhfc_pkg::ST_MAGIC_BAD ||
                   out_result.status == mhfc_pkg::ST_TRUNC ||
                   out_result.status == mhfc_pkg::ST_CSUM_BAD ||
                   out_result.status == mhfc_pkg::ST_EXTRA))
    else $error("verdict status out of range");

  a_stall_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid && !advance) |=> (beat_valid && $stable(beat)))
    else $error("buffered byte lost during a stall");

  a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && beat_valid && beat.last_byte) |=> out_valid)
    else $error("last byte gave no verdict");

endmodule

// File: tb/sv/message_header_frame_checker_top_test.sv
module message_header_frame_checker_top_test;

  localparam int unsigned MAX_PL = 40;
  localparam int unsigned POS_LIM = mhfc_pkg::HDR_BYTES + MAX_PL + 1;
  localparam int unsigned ITEMS = 650;
  localparam int unsigned MIN_MSGS = 16;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned QUIET_TAIL = 100;
  localparam int unsigned WATCHDOG = 1000;

  typedef enum int {
    MSG_OK, MSG_SHORT, MSG_MAGIC, MSG_TRUNC, MSG_CSUM, MSG_EXTRA, MSG_LONG, MSG_NOISE
  } msg_kind_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain_first;
  } send_beat_t;

  logic clk;
  logic rst_n;

  mhfc_in_if  in_ch();
  mhfc_out_if out_ch();

  message_header_frame_checker_top #(.MAX_PAYLOAD(MAX_PL)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  send_beat_t          byte_q[$];
  mhfc_pkg::result_t   verdict_q[$];

  int unsigned frame_pos = 0;
  logic [31:0] cmd_word = '0;
  logic [31:0] len_word = '0;
  logic [31:0] csum_word = '0;
  logic [31:0] magic_word = '0;
  logic [31:0] sum_word = '0;

  int unsigned beats_in = 0;
  int unsigned hold_at = 0;
  int unsigned quiet_from = 32'hffff_ffff;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 0;
  int unsigned stuck_cycles = 0;
  int unsigned mismatches = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %08h, expected %08h", what, got, want);
    mismatches++;
  endtask

  // Advances the frame state by one byte and gives the verdict on a last byte.
  function automatic void frame_step(input logic [7:0] b, input logic last,
                                     output bit has_verdict,
                                     output mhfc_pkg::result_t verdict);
    int unsigned idx;
    int unsigned sh;
    longint unsigned size;
    longint unsigned need;
    mhfc_pkg::status_t st;
    idx = frame_pos;
    sh = (idx % 4) * 8;
    has_verdict = 0;
    verdict = '0;
    if (idx < mhfc_pkg::HDR_BYTES) begin
      if (idx < mhfc_pkg::CMD_END) cmd_word[sh +: 8] = b;
      else if (idx >= mhfc_pkg::LEN_BASE && idx < mhfc_pkg::CHK_BASE) len_word[sh +: 8] = b;
      else if (idx >= mhfc_pkg::CHK_BASE && idx < mhfc_pkg::MAG_BASE) csum_word[sh +: 8] = b;
      else if (idx >= mhfc_pkg::MAG_BASE) magic_word[sh +: 8] = b;
    end else if (idx < POS_LIM && (idx - mhfc_pkg::HDR_BYTES) < len_word) begin
      sum_word = sum_word + 32'(b);
    end
    frame_pos = (idx < POS_LIM) ? idx + 1 : POS_LIM;
    if (last) begin
      size = frame_pos;
      need = 64'(mhfc_pkg::HDR_BYTES) + 64'(len_word);
      if (size < mhfc_pkg::HDR_BYTES) st = mhfc_pkg::ST_SHORT_HDR;
      else if (cmd_word != (magic_word ^ mhfc_pkg::MAGIC_INV)) st = mhfc_pkg::ST_MAGIC_BAD;
      else if (size < need) st = mhfc_pkg::ST_TRUNC;
      else if (csum_word != sum_word) st = mhfc_pkg::ST_CSUM_BAD;
      else if (size != need) st = mhfc_pkg::ST_EXTRA;
      else st = mhfc_pkg::ST_OK;
      has_verdict = 1;
      verdict.status = st;
      verdict.payload_length = (st == mhfc_pkg::ST_OK) ? len_word : 32'd0;
      verdict.command_word = cmd_word;
      frame_pos = 0;
      cmd_word = '0;
      len_word = '0;
      csum_word = '0;
      magic_word = '0;
      sum_word = '0;
    end
  endfunction

  task automatic queue_byte(input logic [7:0] data, input logic last, input bit drain_first);
    send_beat_t sb;
    sb.data = data;
    sb.last = last;
    sb.drain_first = drain_first;
    byte_q.push_back(sb);
  endtask

  task automatic queue_message(input msg_kind_t kind, input bit drain_first);
    logic [31:0] cmd;
    logic [31:0] len;
    logic [31:0] csum;
    logic [31:0] magic;
    logic [7:0]  pb;
    logic [7:0]  pl[$];
    logic [7:0]  msg[$];
    int unsigned n_pl;
    int unsigned keep;
    int unsigned sh;
    int unsigned i;
    cmd = $urandom;
    magic = cmd ^ mhfc_pkg::MAGIC_INV;
    len = $urandom_range(0, 10);
    if (kind == MSG_LONG) len = $urandom_range(MAX_PL - 2, MAX_PL + 3);
    if (kind == MSG_TRUNC) begin
      if ($urandom_range(0, 2) == 0)
        len = $urandom_range(0, 1) ? 32'hffff_ffff : ($urandom | 32'h100);
      else
        len = $urandom_range(1, MAX_PL);
    end
    n_pl = len;
    if (kind == MSG_TRUNC) n_pl = $urandom_range(0, (len > 20) ? 20 : len - 1);
    else if (kind == MSG_EXTRA) n_pl = len + $urandom_range(1, 4);
    else if (kind == MSG_LONG) n_pl = MAX_PL + 1 + $urandom_range(0, 6);
    csum = '0;
    for (i = 0; i < n_pl; i++) begin
      pb = $urandom;
      pl.push_back(pb);
      if (i < len && i <= MAX_PL) csum = csum + 32'(pb);
    end
    if (kind == MSG_CSUM) csum = csum ^ (32'h1 << $urandom_range(0, 31));
    if (kind == MSG_MAGIC) magic = magic ^ (32'h1 << $urandom_range(0, 31));
    for (i = 0; i < mhfc_pkg::HDR_BYTES; i++) begin
      sh = (i % 4) * 8;
      if (i < mhfc_pkg::CMD_END) msg.push_back(cmd[sh +: 8]);
      else if (i >= mhfc_pkg::LEN_BASE && i < mhfc_pkg::CHK_BASE) msg.push_back(len[sh +: 8]);
      else if (i >= mhfc_pkg::CHK_BASE && i < mhfc_pkg::MAG_BASE) msg.push_back(csum[sh +: 8]);
      else if (i >= mhfc_pkg::MAG_BASE) msg.push_back(magic[sh +: 8]);
      else msg.push_back(8'($urandom));
    end
    foreach (pl[j]) msg.push_back(pl[j]);
    if (kind == MSG_SHORT) begin
      keep = $urandom_range(1, mhfc_pkg::HDR_BYTES - 1);
      while (msg.size() > keep) void'(msg.pop_back());
    end
    if (kind == MSG_NOISE) begin
      msg.delete();
      keep = $urandom_range(1, 40);
      for (i = 0; i < keep; i++) msg.push_back(8'($urandom));
    end
    foreach (msg[j]) queue_byte(msg[j], j == msg.size() - 1, drain_first && j == 0);
  endtask

  always @(posedge clk) begin : drive
    bit                offer;
    bit                got;
    mhfc_pkg::result_t v;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        frame_step(byte_q[0].data, byte_q[0].last, got, v);
        if (got) verdict_q.push_back(v);
        void'(byte_q.pop_front());
        beats_in++;
      end
      offer = 0;
      if (in_ch.valid && !in_ch.ready) begin
        offer = 1;
      end else if (byte_q.size() == 0) begin
        offer = 0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (byte_q[0].drain_first && verdict_q.size() != 0) begin
        offer = 0;
      end else if (beats_in < quiet_from && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 2);
      end else begin
        offer = 1;
      end
      in_ch.valid <= offer;
      if (offer) begin
        in_ch.data_byte <= byte_q[0].data;
        in_ch.last_byte <= byte_q[0].last;
      end
    end
  end

  always @(posedge clk) begin : receive
    bit                rdy;
    mhfc_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with none pending", 32'(out_ch.status), 32'd0);
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
          if (out_ch.payload_length !== want.payload_length)
            report_mismatch("payload_length", out_ch.payload_length, want.payload_length);
          if (out_ch.command_word !== want.command_word)
            report_mismatch("command_word", out_ch.command_word, want.command_word);
        end
      end
      if (!long_hold_done && beats_in >= hold_at) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 0;
      end else if (beats_in < quiet_from && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 2);
        rdy = 0;
      end else begin
        rdy = 1;
      end
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned r;
    int unsigned msgs;
    msg_kind_t   kind;
    rst_n = 1'b0;

    // A one-byte message, then a bare header with zero length and inverted magic.
    queue_byte(8'hff, 1'b1, 1'b0);
    for (i = 0; i < mhfc_pkg::HDR_BYTES; i++)
      queue_byte((i >= mhfc_pkg::MAG_BASE) ? 8'hff : 8'h00, i == mhfc_pkg::HDR_BYTES - 1,
                 1'b0);

    msgs = 0;
    while (byte_q.size() < ITEMS || msgs < MIN_MSGS) begin
      if (msgs == 6) begin
        // One-byte messages keep verdicts coming while the receiver holds off.
        hold_at = byte_q.size();
        for (i = 0; i < 30; i++) queue_byte(8'($urandom), 1'b1, 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 45) kind = MSG_OK;
      else if (r < 55) kind = MSG_SHORT;
      else if (r < 63) kind = MSG_MAGIC;
      else if (r < 72) kind = MSG_TRUNC;
      else if (r < 80) kind = MSG_CSUM;
      else if (r < 88) kind = MSG_EXTRA;
      else if (r < 94) kind = MSG_LONG;
      else kind = MSG_NOISE;
      queue_message(kind, msgs == 15);
      msgs++;
    end
    quiet_from = byte_q.size() - QUIET_TAIL;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
